@@ hw/rtl/fkfs_pkg.sv @@
package fkfs_pkg;

    // register indexes on the configuration port
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAYER_PHASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ISO_LEVEL   = 3'd4;

    localparam int unsigned PHASE_W = 32;
    localparam int unsigned FIELD_W = 18;
    localparam int unsigned TRIG_W  = 16;   // signed Q1.15
    localparam int unsigned MAG_W   = 15;   // unsigned magnitude in the quarter table
    localparam int unsigned FRAC_W  = 15;
    localparam int unsigned IN_FIELD_W = 17;

    localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd1717987;

    localparam logic signed [FIELD_W-1:0] FIELD_MAX = 18'sd98301;
    localparam logic signed [FIELD_W-1:0] FIELD_MIN = -18'sd98301;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // round(32767 * sin(r/quarter * pi/2)), Taylor series in Q30, elaboration only
    function automatic logic [MAG_W-1:0] f_quarter_sine(input int unsigned r,
                                                         input int unsigned tb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] trm;
        logic [63:0] acc;
        logic [63:0] v;
        x   = (HALF_PI_Q30 * 64'(r)) >> (tb - 2);
        x2  = (x * x) >> 30;
        trm = x;
        acc = x;
        trm = ((trm * x2) >> 30) / 64'd6;   acc = acc - trm;
        trm = ((trm * x2) >> 30) / 64'd20;  acc = acc + trm;
        trm = ((trm * x2) >> 30) / 64'd42;  acc = acc - trm;
        trm = ((trm * x2) >> 30) / 64'd72;  acc = acc + trm;
        trm = ((trm * x2) >> 30) / 64'd110; acc = acc - trm;
        trm = ((trm * x2) >> 30) / 64'd156; acc = acc + trm;
        trm = ((trm * x2) >> 30) / 64'd210; acc = acc - trm;
        trm = ((trm * x2) >> 30) / 64'd272; acc = acc + trm;
        trm = ((trm * x2) >> 30) / 64'd342; acc = acc - trm;
        trm = ((trm * x2) >> 30) / 64'd420; acc = acc + trm;
        trm = ((trm * x2) >> 30) / 64'd506; acc = acc - trm;
        trm = ((trm * x2) >> 30) / 64'd600; acc = acc + trm;
        trm = ((trm * x2) >> 30) / 64'd702; acc = acc - trm;
        v = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return MAG_W'(v);
    endfunction

endpackage

@@ hw/rtl/fischer_koch_field_sampler.sv @@
// Fischer-Koch S field sampler. Each input word carries a raster position (row, column);
// each output word carries cos2x.siny.cosz + cos2y.sinz.cosx + cos2z.sinx.cosy in Q.15
// (18 bit signed) and a flag set when that value is at or above iso_level. Angles are
// 32-bit turn fractions: x = x_origin_phase + column*phase_step, y likewise from row,
// z = layer_phase, all wrapping. Sine/cosine come from a quarter-wave ROM of
// 2^(TABLE_BITS-2)+1 entries built at elaboration, folded by quadrant. Throughput is one
// word per clock unless the output stalls; behind the input register a word passes multiply,
// add, fold, ROM read, sign, product, product and sum. Every stage holds under back-pressure
// and bubbles are squeezed out, so input is taken whenever any stage ahead has room. The z
// terms are looked up continuously from layer_phase via address, ROM and sign registers and
// settle before any word taken after a write reaches the products; the user must write
// registers only with the pipeline empty, and the block does not enforce it.
module fischer_koch_field_sampler #(
    parameter int unsigned TABLE_BITS = 10,
    parameter int unsigned COORD_BITS = 17
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave side
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [39:0]                    i_s_axis_tdata,  // [16:0] row, [33:17] column
    // master side
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [23:0]                    o_m_axis_tdata,  // [17:0] field_value, [18] at_or_above
    // configuration
    input  logic                           i_cfg_we,
    input  logic [fkfs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_wdata
);
    import fkfs_pkg::*;

    localparam int unsigned TB      = TABLE_BITS;
    localparam int unsigned QUARTER = 2 ** (TB - 2);
    localparam int unsigned QW      = TB - 1;          // holds 0 .. QUARTER
    localparam int unsigned CW      = (COORD_BITS < IN_FIELD_W) ? COORD_BITS : IN_FIELD_W;
    localparam int unsigned NS      = 9;               // pipeline depth
    localparam int unsigned NL      = 6;               // x/y lookups per word
    localparam int unsigned NZ      = 3;               // z lookups

    // lookup slots
    localparam int unsigned L_SX  = 0;
    localparam int unsigned L_CX  = 1;
    localparam int unsigned L_SY  = 2;
    localparam int unsigned L_CY  = 3;
    localparam int unsigned L_C2X = 4;
    localparam int unsigned L_C2Y = 5;
    localparam int unsigned Z_S   = 0;
    localparam int unsigned Z_C   = 1;
    localparam int unsigned Z_C2  = 2;

    typedef logic [MAG_W-1:0] t_qtab [0:QUARTER];
    typedef logic [QW:0]      t_fold;   // {negate, address}

    function automatic t_qtab f_build_qtab();
        t_qtab t;
        for (int unsigned r = 0; r <= QUARTER; r++) begin
            t[r] = f_quarter_sine(r, TB);
        end
        return t;
    endfunction

    localparam t_qtab QTAB = f_build_qtab();

    // fold a full-turn index into a quarter-wave address and a sign
    function automatic t_fold f_fold(input logic [TB-1:0] idx);
        logic [1:0]    q;
        logic [TB-3:0] r;
        logic [QW-1:0] a;
        q = idx[TB-1:TB-2];
        r = idx[TB-3:0];
        a = q[0] ? (QW'(QUARTER) - QW'(r)) : QW'(r);
        return {q[1], a};
    endfunction

    // ---- configuration registers
    logic [PHASE_W-1:0]        r_phase_step;
    logic [PHASE_W-1:0]        r_x_origin;
    logic [PHASE_W-1:0]        r_y_origin;
    logic [PHASE_W-1:0]        r_layer_phase;
    logic signed [FIELD_W-1:0] r_iso_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step  <= PHASE_STEP_RST;
            r_x_origin    <= '0;
            r_y_origin    <= '0;
            r_layer_phase <= '0;
            r_iso_level   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PHASE_STEP:  r_phase_step  <= i_cfg_wdata;
                REG_X_ORIGIN:    r_x_origin    <= i_cfg_wdata;
                REG_Y_ORIGIN:    r_y_origin    <= i_cfg_wdata;
                REG_LAYER_PHASE: r_layer_phase <= i_cfg_wdata;
                REG_ISO_LEVEL:   r_iso_level   <= i_cfg_wdata[FIELD_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---- stage valids and hold chain
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || i_m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = w_en[0];

    // ---- s0: capture coordinates
    logic [CW-1:0] r_row;
    logic [CW-1:0] r_col;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_row <= i_s_axis_tdata[CW-1:0];
            r_col <= i_s_axis_tdata[IN_FIELD_W +: CW];
        end
    end

    // ---- s1: coordinate times phase step, low 32 bits
    logic [PHASE_W-1:0] r_xp;
    logic [PHASE_W-1:0] r_yp;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_xp <= PHASE_W'(r_col * r_phase_step);
            r_yp <= PHASE_W'(r_row * r_phase_step);
        end
    end

    // ---- s2: add origin
    logic [PHASE_W-1:0] r_x;
    logic [PHASE_W-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_x <= r_x_origin + r_xp;
            r_y <= r_y_origin + r_yp;
        end
    end

    // ---- s3: table index and quadrant fold
    t_fold w_fold [NL];
    logic [QW-1:0] r_addr [NL];
    logic [NL-1:0] r_neg3;

    always_comb begin
        w_fold[L_SX]  = f_fold(r_x[PHASE_W-1 -: TB]);
        w_fold[L_CX]  = f_fold(r_x[PHASE_W-1 -: TB] + TB'(QUARTER));
        w_fold[L_SY]  = f_fold(r_y[PHASE_W-1 -: TB]);
        w_fold[L_CY]  = f_fold(r_y[PHASE_W-1 -: TB] + TB'(QUARTER));
        w_fold[L_C2X] = f_fold(r_x[PHASE_W-2 -: TB] + TB'(QUARTER));   // doubled angle
        w_fold[L_C2Y] = f_fold(r_y[PHASE_W-2 -: TB] + TB'(QUARTER));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            for (int k = 0; k < NL; k++) begin
                r_addr[k] <= w_fold[k][QW-1:0];
                r_neg3[k] <= w_fold[k][QW];
            end
        end
    end

    // ---- s4: ROM read, one copy per read port
    logic [MAG_W-1:0] r_mag [NL];
    logic [NL-1:0]    r_neg4;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            for (int k = 0; k < NL; k++) begin
                r_mag[k] <= QTAB[r_addr[k]];
            end
            r_neg4 <= r_neg3;
        end
    end

    // ---- s5: apply quadrant sign
    logic signed [TRIG_W-1:0] r_trig [NL];

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            for (int k = 0; k < NL; k++) begin
                r_trig[k] <= r_neg4[k] ? -$signed({1'b0, r_mag[k]})
                                       :  $signed({1'b0, r_mag[k]});
            end
        end
    end

    // ---- z path: free-running lookups from layer_phase
    t_fold                    w_zfold [NZ];
    logic [QW-1:0]            r_zaddr [NZ];
    logic [NZ-1:0]            r_zneg_a;
    logic [NZ-1:0]            r_zneg_b;
    logic [MAG_W-1:0]         r_zmag  [NZ];
    logic signed [TRIG_W-1:0] r_ztrig [NZ];

    always_comb begin
        w_zfold[Z_S]  = f_fold(r_layer_phase[PHASE_W-1 -: TB]);
        w_zfold[Z_C]  = f_fold(r_layer_phase[PHASE_W-1 -: TB] + TB'(QUARTER));
        w_zfold[Z_C2] = f_fold(r_layer_phase[PHASE_W-2 -: TB] + TB'(QUARTER));
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NZ; k++) begin
            r_zaddr[k]  <= w_zfold[k][QW-1:0];
            r_zneg_a[k] <= w_zfold[k][QW];
            r_zmag[k]   <= QTAB[r_zaddr[k]];
            r_zneg_b[k] <= r_zneg_a[k];
            r_ztrig[k]  <= r_zneg_b[k] ? -$signed({1'b0, r_zmag[k]})
                                       :  $signed({1'b0, r_zmag[k]});
        end
    end

    // ---- s6: first products, floor shift by 15
    logic signed [2*TRIG_W-1:0] w_m6 [3];
    logic signed [TRIG_W-1:0]   r_p  [3];
    logic signed [TRIG_W-1:0]   r_cx6;
    logic signed [TRIG_W-1:0]   r_cy6;

    always_comb begin
        w_m6[0] = r_trig[L_C2X] * r_trig[L_SY];
        w_m6[1] = r_trig[L_C2Y] * r_ztrig[Z_S];
        w_m6[2] = r_ztrig[Z_C2] * r_trig[L_SX];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            for (int k = 0; k < 3; k++) begin
                r_p[k] <= TRIG_W'(w_m6[k] >>> FRAC_W);
            end
            r_cx6 <= r_trig[L_CX];
            r_cy6 <= r_trig[L_CY];
        end
    end

    // ---- s7: second products
    logic signed [2*TRIG_W-1:0] w_m7 [3];
    logic signed [TRIG_W-1:0]   r_t  [3];

    always_comb begin
        w_m7[0] = r_p[0] * r_ztrig[Z_C];
        w_m7[1] = r_p[1] * r_cx6;
        w_m7[2] = r_p[2] * r_cy6;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            for (int k = 0; k < 3; k++) begin
                r_t[k] <= TRIG_W'(w_m7[k] >>> FRAC_W);
            end
        end
    end

    // ---- s8: sum and iso compare, output register
    logic signed [FIELD_W-1:0] w_sum;
    logic signed [FIELD_W-1:0] r_field;
    logic                      r_above;

    assign w_sum = FIELD_W'(r_t[0]) + FIELD_W'(r_t[1]) + FIELD_W'(r_t[2]);

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_field <= w_sum;
            r_above <= (w_sum >= r_iso_level);
        end
    end

    assign o_m_axis_tvalid = r_v[NS-1];
    assign o_m_axis_tdata  = {5'd0, r_above, r_field};

endmodule

@@ hw/rtl/fkfs_checker.sv @@
module fkfs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata
);
    import fkfs_pkg::*;

    logic signed [FIELD_W-1:0] w_field;
    assign w_field = o_m_axis_tdata[FIELD_W-1:0];

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output word changed while stalled");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid straight after reset");

    // an empty output stage never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked with no output pending");

    // sum of three Q.15 products stays in range
    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_field >= FIELD_MIN) && (w_field <= FIELD_MAX))
        else $error("field value out of range");

endmodule

bind fischer_koch_field_sampler fkfs_checker u_fkfs_checker (.*);

@@ bench/fischer_koch_field_sampler_tb.sv @@
module fischer_koch_field_sampler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fkfs_pkg::*;

    localparam int unsigned TB_TABLE_BITS = 10;
    localparam int unsigned TB_COORD_BITS = 17;
    localparam int unsigned ROM_SIZE      = 1 << TB_TABLE_BITS;
    localparam int unsigned ROM_QUARTER   = ROM_SIZE >> 2;
    // pi/2 in Q30, the argument scale for the series
    localparam longint unsigned RIGHT_ANGLE_Q30 = 64'd1686629713;
    localparam int unsigned PIPE_SETTLE  = 12;      // pipeline latency plus margin
    localparam int unsigned LONG_HOLD    = 300;     // receiver hold-off, cycles
    localparam int unsigned RAND_PHASES  = 10;
    localparam int unsigned PHASE_WORDS  = 60;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    // indexes beyond the last register: writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_ISO_LEVEL + 1'b1;

    typedef struct packed {
        logic [IN_FIELD_W-1:0] column;
        logic [IN_FIELD_W-1:0] row;
    } t_point;

    typedef struct packed {
        logic signed [FIELD_W-1:0] value;
        logic                      above;
    } t_sample;

    // DUT connections; every input starts at a known value
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [39:0]          i_s_axis_tdata;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [23:0]          o_m_axis_tdata;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_wdata = '0;

    t_point held_point = '0;
    assign i_s_axis_tdata = {6'd0, held_point.column, held_point.row};

    // register copy used by the predictor
    logic [PHASE_W-1:0]        step_m;
    logic [PHASE_W-1:0]        x_origin_m;
    logic [PHASE_W-1:0]        y_origin_m;
    logic [PHASE_W-1:0]        layer_m;
    logic signed [FIELD_W-1:0] iso_m;

    longint sine_rom [ROM_SIZE];

    t_point  pending_points[$];
    t_sample field_samples[$];

    int unsigned points_queued    = 0;
    int unsigned samples_received = 0;
    int unsigned mismatches       = 0;
    int unsigned cycle_count      = 0;
    int unsigned gap_left         = 0;
    int unsigned stall_left       = 0;
    int unsigned hold_asked       = 0;
    int unsigned hold_taken       = 0;
    bit          src_idle_on      = 1'b1;
    bit          sink_idle_on     = 1'b1;

    fischer_koch_field_sampler #(
        .TABLE_BITS (TB_TABLE_BITS),
        .COORD_BITS (TB_COORD_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [16:0] row, [33:17] column
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [17:0] field_value, [18] at_or_above
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // ---------------------------------------------------------------- predictor

    // 32767*sin(r/quarter * pi/2), odd Taylor series up to x^27 in Q30, rounded
    function automatic longint quarter_wave(input int unsigned r);
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned trm;
        longint unsigned acc;
        longint unsigned mag;
        ang  = (RIGHT_ANGLE_Q30 * longint'(r)) >> (TB_TABLE_BITS - 2);
        ang2 = (ang * ang) >> 30;
        trm  = ang;
        acc  = ang;
        for (int k = 1; k < 14; k++) begin
            trm = ((trm * ang2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - trm;
            end else begin
                acc = acc + trm;
            end
        end
        mag = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return longint'(mag);
    endfunction

    // full wave unfolded from the quarter by quadrant
    task automatic build_sine_rom();
        int unsigned quad;
        int unsigned r;
        for (int unsigned i = 0; i < ROM_SIZE; i++) begin
            quad = i / ROM_QUARTER;
            r    = i % ROM_QUARTER;
            case (quad)
                0:       sine_rom[i] = quarter_wave(r);
                1:       sine_rom[i] = quarter_wave(ROM_QUARTER - r);
                2:       sine_rom[i] = -quarter_wave(r);
                default: sine_rom[i] = -quarter_wave(ROM_QUARTER - r);
            endcase
        end
    endtask

    function automatic longint sin_at(input logic [PHASE_W-1:0] a);
        return sine_rom[a >> (PHASE_W - TB_TABLE_BITS)];
    endfunction

    function automatic longint cos_at(input logic [PHASE_W-1:0] a);
        return sine_rom[((a >> (PHASE_W - TB_TABLE_BITS)) + ROM_QUARTER) % ROM_SIZE];
    endfunction

    // ((a*b) >> 15) * c >> 15, floor shifts
    function automatic longint triple_product(input longint a, input longint b,
                                              input longint c);
        longint p;
        p = (a * b) >>> FRAC_W;
        return (p * c) >>> FRAC_W;
    endfunction

    function automatic t_sample predict_sample(input t_point pt);
        logic [PHASE_W-1:0] ax;
        logic [PHASE_W-1:0] ay;
        logic [PHASE_W-1:0] az;
        longint             sum;
        t_sample            s;
        ax  = x_origin_m + pt.column * step_m;
        ay  = y_origin_m + pt.row * step_m;
        az  = layer_m;
        sum = triple_product(cos_at(ax << 1), sin_at(ay), cos_at(az))
            + triple_product(cos_at(ay << 1), sin_at(az), cos_at(ax))
            + triple_product(cos_at(az << 1), sin_at(ax), cos_at(ay));
        s.value = sum[FIELD_W-1:0];
        s.above = (sum >= longint'(iso_m));
        return s;
    endfunction

    // ---------------------------------------------------------------- driver
    // Offers queued words; once valid is up it stays until taken. Idle bursts
    // only fall between words.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                field_samples = {field_samples, predict_sample(held_point)};
            end
            if (i_s_axis_tvalid && !o_s_axis_tready) begin
                // word still waiting, hold everything
            end else if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (src_idle_on && $urandom_range(0, 3) == 0) begin
                gap_left = $urandom_range(0, 7);
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_points.size() > 0) begin
                held_point      <= pending_points.pop_front();
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    // Checks each taken word against the oldest prediction and drives tready,
    // with random stall bursts and the occasional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                samples_received = samples_received + 1;
                if (field_samples.size() == 0) begin
                    $error("unexpected word: field_value %0d at_or_above %0b",
                           $signed(o_m_axis_tdata[FIELD_W-1:0]), o_m_axis_tdata[FIELD_W]);
                    mismatches = mismatches + 1;
                end else begin
                    t_sample want;
                    want = field_samples.pop_front();
                    if (o_m_axis_tdata[FIELD_W-1:0] !== want.value) begin
                        $error("field_value: expected %0d, got %0d", want.value,
                               $signed(o_m_axis_tdata[FIELD_W-1:0]));
                        mismatches = mismatches + 1;
                    end
                    if (o_m_axis_tdata[FIELD_W] !== want.above) begin
                        $error("at_or_above: expected %0b, got %0b", want.above,
                               o_m_axis_tdata[FIELD_W]);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (hold_taken != hold_asked) begin
                hold_taken = hold_asked;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_m_axis_tready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 7);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("fischer_koch_field_sampler_tb: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequencing

    // one register write, mirrored the way the block keeps it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_PHASE_STEP:  step_m     = val;
            REG_X_ORIGIN:    x_origin_m = val;
            REG_Y_ORIGIN:    y_origin_m = val;
            REG_LAYER_PHASE: layer_m    = val;
            REG_ISO_LEVEL:   iso_m      = val[FIELD_W-1:0];
            default:         ;  // no register there
        endcase
    endtask

    // full register set, then a few quiet clocks so the z lookups settle
    task automatic program_field(input logic [31:0] step, input logic [31:0] xo,
                                 input logic [31:0] yo, input logic [31:0] layer,
                                 input logic [31:0] iso);
        write_reg(REG_PHASE_STEP, step);
        write_reg(REG_X_ORIGIN, xo);
        write_reg(REG_Y_ORIGIN, yo);
        write_reg(REG_LAYER_PHASE, layer);
        write_reg(REG_ISO_LEVEL, iso);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic queue_point(input logic [IN_FIELD_W-1:0] row,
                               input logic [IN_FIELD_W-1:0] column);
        t_point pt;
        pt.row    = row;
        pt.column = column;
        pending_points = {pending_points, pt};
        points_queued = points_queued + 1;
    endtask

    // sender pauses here until every word sent has come back
    task automatic drain();
        while (samples_received < points_queued) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        logic [IN_FIELD_W-1:0] base_r;
        logic [IN_FIELD_W-1:0] base_c;
        logic [31:0]           step;
        logic [31:0]           layer;
        int                    iso;
        t_point                eq_pt;
        t_sample               eq_s;

        build_sine_rom();
        step_m     = PHASE_STEP_RST;
        x_origin_m = '0;
        y_origin_m = '0;
        layer_m    = '0;
        iso_m      = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (PIPE_SETTLE) @(posedge i_clk);

        // reset settings: field extremes and alternating bit patterns
        queue_point('0, '0);
        queue_point('1, '1);
        queue_point('0, '1);
        queue_point('1, '0);
        queue_point(17'h15555, 17'h0AAAA);
        queue_point(17'h0AAAA, 17'h15555);
        queue_point(17'd1, 17'h10000);
        queue_point(17'h10000, 17'd1);
        drain();

        // step and x origin at the top of the turn, y origin at half, layer at a quarter, lowest
        // iso level; writes to the unused indexes must leave the field untouched
        program_field('1, '1, 32'h8000_0000, 32'h4000_0000, 32'(FIELD_MIN));
        for (int k = REG_SPARE_FIRST; k < (1 << CFG_IDX_W); k++) begin
            write_reg(CFG_IDX_W'(k), $urandom());
        end
        repeat (PIPE_SETTLE) @(posedge i_clk);
        queue_point('0, '0);
        queue_point('1, '1);
        queue_point('0, '1);
        queue_point('1, '0);
        queue_point(17'h15555, 17'h0AAAA);
        queue_point(17'h00001, 17'h1FFFE);
        queue_point(17'h1FFFE, 17'h00001);
        drain();

        // zero step pins every position to the origin; iso written with junk
        // above bit 17, only the low bits count
        program_field('0, 32'hC000_0000, 32'h2000_0000, '1,
                      32'hFFFC_0000 | 32'(FIELD_MAX));
        queue_point('0, '0);
        queue_point('1, '1);
        queue_point(17'h0AAAA, 17'h15555);
        queue_point(17'h12345, 17'h0ABCD);
        drain();

        // field exactly at the iso level
        program_field(32'h0123_4567, 32'h1357_9BDF, 32'h2468_ACE0, 32'h0F0F_0F0F, '0);
        eq_pt.row    = 17'h00321;
        eq_pt.column = 17'h01234;
        eq_s = predict_sample(eq_pt);
        write_reg(REG_ISO_LEVEL, 32'(eq_s.value));
        repeat (PIPE_SETTLE) @(posedge i_clk);
        queue_point(eq_pt.row, eq_pt.column);
        queue_point(eq_pt.row, eq_pt.column + 1'b1);
        queue_point(eq_pt.row + 1'b1, eq_pt.column);
        queue_point('1, '0);
        drain();

        // random part: a fresh field per phase, half raster scans, half scatter
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            // a stretch without idling in the middle, none at all at the end
            src_idle_on  = (ph != 6) && (ph != RAND_PHASES - 1);
            sink_idle_on = src_idle_on;

            case ($urandom_range(0, 3))
                0:       step = $urandom();
                1:       step = $urandom_range(1, 32'h0010_0000);
                2:       step = PHASE_STEP_RST + $urandom_range(0, 32'h0000_FFFF);
                default: step = $urandom_range(0, 1) ? '1 : '0;
            endcase
            layer = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? '1 : '0)
                                              : $urandom();
            case ($urandom_range(0, 4))
                0:       iso = $urandom_range(0, 1) ? int'(FIELD_MAX) : int'(FIELD_MIN);
                1:       iso = int'($urandom_range(0, 196602)) - 98301;
                default: iso = int'($urandom_range(0, 40000)) - 20000;
            endcase
            program_field(step, $urandom(), $urandom(), layer, 32'(iso));
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, (1 << CFG_IDX_W) - 1)),
                          $urandom());
                repeat (PIPE_SETTLE) @(posedge i_clk);
            end

            base_r = IN_FIELD_W'($urandom_range(0, 131071));
            base_c = IN_FIELD_W'($urandom_range(0, 131071));
            for (int j = 0; j < PHASE_WORDS / 2; j++) begin
                queue_point(base_r + IN_FIELD_W'(j / 8), base_c + IN_FIELD_W'(j % 8));
            end
            for (int j = 0; j < PHASE_WORDS / 2; j++) begin
                queue_point(IN_FIELD_W'($urandom_range(0, 131071)),
                            IN_FIELD_W'($urandom_range(0, 131071)));
            end

            // receiver goes deaf for a while so the pipe fills and tready drops
            if (ph == 3) begin
                hold_asked = hold_asked + 1;
            end
            drain();
        end

        repeat (PIPE_SETTLE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("fischer_koch_field_sampler_tb: done, clean");
        end else begin
            $display("fischer_koch_field_sampler_tb: done, errors");
        end
        $finish;
    end

endmodule
